/* hdl/nfcs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package nfcs_pkg;

  localparam int OFFSET_W  = 23;
  localparam int ADDR_W    = 22;
  localparam int DATA_W    = 16;
  localparam int QREG_W    = 8;
  localparam int CMD_W     = 3;
  localparam int LOG2_W    = 5;
  localparam int POS_W     = 4;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 40;

  localparam int DEF_WORD_ADDR_BITS = 22;

  localparam logic [LOG2_W-1:0] LOG2_MIN   = 5'd8;
  localparam logic [LOG2_W-1:0] LOG2_MAX   = 5'd21;
  localparam logic [LOG2_W-1:0] LOG2_RESET = 5'd12;

  localparam logic [ADDR_W-1:0] UNLOCK_ADDR1 = 22'h000555;
  localparam logic [ADDR_W-1:0] UNLOCK_ADDR2 = 22'h0002AA;

  localparam logic [7:0] DATA_UNLOCK1 = 8'hAA;
  localparam logic [7:0] DATA_UNLOCK2 = 8'h55;
  localparam logic [7:0] DATA_RESET   = 8'hF0;
  localparam logic [7:0] DATA_PROGRAM = 8'hA0;
  localparam logic [7:0] DATA_ERASE   = 8'h80;
  localparam logic [7:0] DATA_BLK_ERS = 8'h30;
  localparam logic [7:0] DATA_CHIP_ERS = 8'h10;
  localparam logic [7:0] DATA_QUERY   = 8'h98;

  localparam int DQ6_BIT = 6;
  localparam int DQ5_BIT = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ       = 3'd0,
    CMD_PROG       = 3'd1,
    CMD_BLK_ERASE  = 3'd2,
    CMD_CHIP_ERASE = 3'd3,
    CMD_QUERY      = 3'd4,
    CMD_STATUS     = 3'd5,
    CMD_RESET      = 3'd6,
    CMD_NONE       = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_READ   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BUSY      = 2'd1,
    ST_DEV_ERR   = 2'd2,
    ST_BAD_ALIGN = 2'd3
  } status_t;

  // unlock body ahead of the final access: 0, 2, 3 or 5 writes
  typedef enum logic [1:0] {
    BODY_NONE   = 2'd0,
    BODY_UNLOCK = 2'd1,
    BODY_CMD    = 2'd2,
    BODY_ERASE  = 2'd3
  } body_t;

  // script positions: reset sequence, unlock body, final access
  localparam logic [POS_W-1:0] POS_RST_AA  = 4'd0;
  localparam logic [POS_W-1:0] POS_RST_55  = 4'd1;
  localparam logic [POS_W-1:0] POS_RST_F0  = 4'd2;
  localparam logic [POS_W-1:0] POS_BODY_AA = 4'd3;
  localparam logic [POS_W-1:0] POS_BODY_55 = 4'd4;
  localparam logic [POS_W-1:0] POS_BODY_MID = 4'd5;
  localparam logic [POS_W-1:0] POS_BODY_AA2 = 4'd6;
  localparam logic [POS_W-1:0] POS_BODY_552 = 4'd7;
  localparam logic [POS_W-1:0] POS_FINAL   = 4'd8;

  typedef struct packed {
    logic                 valid;
    logic                 rst_pfx;
    body_t                body;
    logic [7:0]           mid;
    kind_t                kind;
    logic [ADDR_W-1:0]    addr;
    logic [DATA_W-1:0]    data;
    status_t              code;
  } seq_t;

  typedef struct packed {
    logic              program_mode;
    logic              error_pending;
    logic [ADDR_W-1:0] poll_address;
  } ctl_state_t;

  function automatic logic [POS_W-1:0] body_end(input body_t body);
    logic [POS_W-1:0] p;
    unique case (body)
      BODY_UNLOCK: p = POS_BODY_55;
      BODY_CMD:    p = POS_BODY_MID;
      BODY_ERASE:  p = POS_BODY_552;
      BODY_NONE:   p = POS_FINAL;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

/* hdl/nfcs_decode.sv */
`timescale 1ns / 1ps
`default_nettype none

module nfcs_decode #(
  parameter int WORD_ADDR_BITS = nfcs_pkg::DEF_WORD_ADDR_BITS
) (
  input  wire logic [nfcs_pkg::CMD_W-1:0]    cmd,
  input  wire logic [nfcs_pkg::OFFSET_W-1:0] byte_offset,
  input  wire logic [nfcs_pkg::DATA_W-1:0]   write_data,
  input  wire logic [nfcs_pkg::QREG_W-1:0]   query_reg,
  input  wire logic [nfcs_pkg::DATA_W-1:0]   status_first,
  input  wire logic [nfcs_pkg::DATA_W-1:0]   status_second,
  input  wire logic [nfcs_pkg::LOG2_W-1:0]   erase_block_log2,
  input  wire nfcs_pkg::ctl_state_t          cur,
  output nfcs_pkg::seq_t                     seq,
  output nfcs_pkg::ctl_state_t               nxt
);
  import nfcs_pkg::*;

  localparam int EffBits = (WORD_ADDR_BITS < ADDR_W) ? WORD_ADDR_BITS : ADDR_W;
  localparam logic [ADDR_W-1:0] AddrMask = ADDR_W'((64'd1 << EffBits) - 64'd1);

  logic [LOG2_W-1:0]   lg;
  logic [OFFSET_W-1:0] blk_keep;
  logic [OFFSET_W-1:0] blk_off;
  logic [ADDR_W-1:0]   waddr;
  logic [ADDR_W-1:0]   baddr;
  logic [ADDR_W-1:0]   qaddr;
  logic                toggling;
  logic                dq5;

  always_comb begin
    priority if (erase_block_log2 < LOG2_MIN) begin
      lg = LOG2_MIN;
    end else if (erase_block_log2 > LOG2_MAX) begin
      lg = LOG2_MAX;
    end else begin
      lg = erase_block_log2;
    end
  end

  assign blk_keep = ~((OFFSET_W'(1) << lg) - OFFSET_W'(1));
  assign blk_off  = byte_offset & blk_keep;
  assign waddr    = byte_offset[OFFSET_W-1:1] & AddrMask;
  assign baddr    = blk_off[OFFSET_W-1:1] & AddrMask;
  assign qaddr    = {{(ADDR_W-QREG_W){1'b0}}, query_reg} & AddrMask;
  assign toggling = status_first[DQ6_BIT] ^ status_second[DQ6_BIT];
  assign dq5      = status_first[DQ5_BIT] & status_second[DQ5_BIT];

  always_comb begin
    seq         = '0;
    seq.valid   = 1'b1;
    seq.body    = BODY_NONE;
    seq.kind    = KIND_WRITE;
    seq.code    = ST_OK;
    nxt         = cur;
    if (cmd_t'(cmd) != CMD_STATUS && cmd_t'(cmd) != CMD_NONE) begin
      nxt.error_pending = 1'b0;
    end

    unique case (cmd_t'(cmd))
      CMD_READ: begin
        seq.rst_pfx      = cur.program_mode;
        seq.kind         = KIND_READ;
        seq.addr         = waddr;
        nxt.program_mode = 1'b0;
      end
      CMD_PROG: begin
        if (byte_offset[0]) begin
          seq.kind = KIND_STATUS;
          seq.addr = cur.poll_address;
          seq.code = ST_BAD_ALIGN;
        end else begin
          seq.body         = BODY_CMD;
          seq.mid          = DATA_PROGRAM;
          seq.addr         = waddr;
          seq.data         = write_data;
          nxt.poll_address = waddr;
        end
      end
      CMD_BLK_ERASE: begin
        seq.rst_pfx      = cur.program_mode;
        seq.body         = BODY_ERASE;
        seq.mid          = DATA_ERASE;
        seq.addr         = baddr;
        seq.data         = {8'h00, DATA_BLK_ERS};
        nxt.poll_address = baddr;
        nxt.program_mode = 1'b1;
      end
      CMD_CHIP_ERASE: begin
        seq.rst_pfx      = cur.program_mode;
        seq.body         = BODY_ERASE;
        seq.mid          = DATA_ERASE;
        seq.addr         = UNLOCK_ADDR1 & AddrMask;
        seq.data         = {8'h00, DATA_CHIP_ERS};
        nxt.poll_address = '0;
        nxt.program_mode = 1'b1;
      end
      CMD_QUERY: begin
        seq.body         = BODY_CMD;
        seq.mid          = DATA_QUERY;
        seq.kind         = KIND_READ;
        seq.addr         = qaddr;
        nxt.program_mode = 1'b1;
      end
      CMD_STATUS: begin
        seq.kind = KIND_STATUS;
        seq.addr = cur.poll_address;
        priority if (!toggling) begin
          seq.code          = ST_OK;
          nxt.error_pending = 1'b0;
        end else if (dq5 && cur.error_pending) begin
          seq.code          = ST_DEV_ERR;
          nxt.error_pending = 1'b0;
        end else if (dq5) begin
          seq.code          = ST_BUSY;
          nxt.error_pending = 1'b1;
        end else begin
          seq.code          = ST_BUSY;
          nxt.error_pending = 1'b0;
        end
      end
      CMD_RESET: begin
        seq.body         = BODY_UNLOCK;
        seq.addr         = '0;
        seq.data         = {8'h00, DATA_RESET};
        nxt.program_mode = 1'b0;
      end
      CMD_NONE: begin
        seq.valid = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/nor_flash_command_sequencer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Each accepted command loads the script step counter; its results then leave through the output register.
// Throughput: one result per cycle from the output register while out_tready holds; a command
//   gives 0 to 9 results, and the next command is taken in the cycle of the last one.
// The script step counter that walks reset, unlock and final accesses sets the rate.
// Reset: synchronous active-low rst_n clears state flags, poll address, step control and
//   output valid; erase_block_log2 returns to 12.

module nor_flash_command_sequencer_unit #(
  parameter int WORD_ADDR_BITS = nfcs_pkg::DEF_WORD_ADDR_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // byte_offset, write_data, query_reg, status_first, status_second, zero pad
  input  wire logic [nfcs_pkg::IN_DATA_W-1:0]    in_tdata,
  // cmd
  input  wire logic [nfcs_pkg::CMD_W-1:0]        in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // bus_address, bus_data, status_code
  output logic [nfcs_pkg::OUT_DATA_W-1:0]        out_tdata,
  // kind
  output logic [1:0]                             out_tuser,
  output logic                                   out_tlast,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [nfcs_pkg::LOG2_W-1:0]       cfg_data
);
  import nfcs_pkg::*;

  logic [LOG2_W-1:0] log2_r;
  ctl_state_t        st_r;
  ctl_state_t        st_nxt;
  seq_t              seq_r;
  seq_t              seq_dec;
  logic              busy_r;
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  pos_nxt;
  logic [POS_W-1:0]  pos_start;

  logic              out_vld_r;
  kind_t             out_kind_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [DATA_W-1:0] out_data_r;
  status_t           out_code_r;
  logic              out_last_r;

  kind_t             step_kind;
  logic [ADDR_W-1:0] step_addr;
  logic [DATA_W-1:0] step_data;
  status_t           step_code;
  logic              step_last;

  logic              out_free;
  logic              emit;
  logic              accept;

  nfcs_decode #(
    .WORD_ADDR_BITS (WORD_ADDR_BITS)
  ) u_decode (
    .cmd              (in_tuser),
    .byte_offset      (in_tdata[22:0]),
    .write_data       (in_tdata[38:23]),
    .query_reg        (in_tdata[46:39]),
    .status_first     (in_tdata[62:47]),
    .status_second    (in_tdata[78:63]),
    .erase_block_log2 (log2_r),
    .cur              (st_r),
    .seq              (seq_dec),
    .nxt              (st_nxt)
  );

  assign out_free  = !out_vld_r || out_tready;
  assign emit      = busy_r && out_free;
  assign step_last = (pos_r == POS_FINAL);
  assign in_tready = !busy_r || (emit && step_last);
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    step_kind = KIND_WRITE;
    step_addr = UNLOCK_ADDR1;
    step_data = {8'h00, DATA_UNLOCK1};
    step_code = ST_OK;
    unique case (pos_r)
      POS_RST_AA, POS_BODY_AA, POS_BODY_AA2: begin
        step_addr = UNLOCK_ADDR1;
        step_data = {8'h00, DATA_UNLOCK1};
      end
      POS_RST_55, POS_BODY_55, POS_BODY_552: begin
        step_addr = UNLOCK_ADDR2;
        step_data = {8'h00, DATA_UNLOCK2};
      end
      POS_RST_F0: begin
        step_addr = '0;
        step_data = {8'h00, DATA_RESET};
      end
      POS_BODY_MID: begin
        step_addr = UNLOCK_ADDR1;
        step_data = {8'h00, seq_r.mid};
      end
      default: begin
        step_kind = seq_r.kind;
        step_addr = seq_r.addr;
        step_data = seq_r.data;
        step_code = seq_r.code;
      end
    endcase
  end

  always_comb begin
    if (pos_r == POS_RST_F0) begin
      pos_nxt = (seq_r.body == BODY_NONE) ? POS_FINAL : POS_BODY_AA;
    end else if (pos_r >= POS_BODY_AA && pos_r == body_end(seq_r.body)) begin
      pos_nxt = POS_FINAL;
    end else begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  always_comb begin
    if (seq_dec.rst_pfx) begin
      pos_start = POS_RST_AA;
    end else if (seq_dec.body == BODY_NONE) begin
      pos_start = POS_FINAL;
    end else begin
      pos_start = POS_BODY_AA;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log2_r <= LOG2_RESET;
      st_r   <= '0;
      busy_r <= 1'b0;
      pos_r  <= POS_FINAL;
    end else begin
      if (cfg_valid && cfg_ready) begin
        log2_r <= cfg_data;
      end
      if (accept) begin
        st_r   <= st_nxt;
        busy_r <= seq_dec.valid;
        pos_r  <= pos_start;
      end else if (emit) begin
        busy_r <= !step_last;
        pos_r  <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seq_r <= seq_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (emit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= step_kind;
      out_addr_r <= step_addr;
      out_data_r <= step_data;
      out_code_r <= step_code;
      out_last_r <= step_last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_code_r, out_data_r, out_addr_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

/* hdl/nfcs_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module nfcs_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [nfcs_pkg::OUT_DATA_W-1:0]   out_tdata,
  input wire logic [1:0]                        out_tuser,
  input wire logic                              out_tlast
);
  import nfcs_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_STATUS |-> out_tlast)
    else $error("status report not last of its command");

  a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_WRITE |-> out_tdata[37:22] == 16'h0000)
    else $error("read or status carries data");

  a_bus_code_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_STATUS |-> out_tdata[39:38] == ST_OK)
    else $error("bus access carries status code");

endmodule

bind nor_flash_command_sequencer_unit nfcs_checker u_nfcs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
